### hdl/us2x_pkg.sv
// Shared constants, types and arithmetic helpers for the 2x stencil upsampler.
package us2x_pkg;

   // Frame limits and word sizes
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MAX_CHAN    = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int COL_BITS    = 10;
   localparam int ROW_BITS    = 11;
   localparam int CHAN_BITS   = 4;
   localparam int SLOT_BITS   = 2;
   localparam int LINE_DEPTH  = 3 * MAX_WIDTH * MAX_CHAN;
   localparam int ADDR_BITS   = SLOT_BITS + COL_BITS + CHAN_BITS;
   localparam int SUM_BITS    = 20;
   localparam int BIAS_BITS   = 21;
   localparam int PROD_BITS   = 41;

   // floor(u/9) as (u * ceil(2^23/9)) >> 23, exact for u < 2^21
   localparam int RECIP       = 932068;
   localparam int RECIP_SHIFT = 23;
   // rounding term plus offset that makes every weighted sum non-negative
   localparam int SUM_OFFSET  = 9 * 32768 + 4;

   // Configuration register indexes
   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH   = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT  = 2'd2;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // One input column of the stencil: rows above, at and below the center
   typedef struct packed {
      sample_type up;
      sample_type mid;
      sample_type dn;
   } column_type;

   // Per-channel history of the two previous columns
   typedef struct packed {
      column_type prev;
      column_type prev2;
   } hist_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] ul;
      logic signed [SUM_BITS-1:0] ur;
      logic signed [SUM_BITS-1:0] ll;
      logic signed [SUM_BITS-1:0] lr;
   } corner_sum_type;

   typedef struct packed {
      sample_type ul;
      sample_type ur;
      sample_type ll;
      sample_type lr;
   } corner_out_type;

   // Request position and emission flags carried down the pipeline
   typedef struct packed {
      logic [COL_BITS-1:0]  col;
      logic [COL_BITS-1:0]  cy;
      logic [CHAN_BITS-1:0] ch;
      logic                 emit_a;
      logic                 emit_b;
      logic                 last_b;
   } meta_type;

   // diag + 2*vert + 2*horiz + 4*center
   function automatic logic signed [SUM_BITS-1:0] corner(sample_type d, sample_type v,
                                                         sample_type h, sample_type c);
      logic signed [SUM_BITS-1:0] dx;
      logic signed [SUM_BITS-1:0] vx;
      logic signed [SUM_BITS-1:0] hx;
      logic signed [SUM_BITS-1:0] cx;
      dx = SUM_BITS'(d);
      vx = SUM_BITS'(v);
      hx = SUM_BITS'(h);
      cx = SUM_BITS'(c);
      return dx + (vx <<< 1) + (hx <<< 1) + (cx <<< 2);
   endfunction

   // floor((s + 4) / 9) via biased reciprocal multiply
   function automatic sample_type ninth(logic signed [SUM_BITS-1:0] s);
      logic [BIAS_BITS-1:0] u;
      logic [PROD_BITS-1:0] p;
      u = BIAS_BITS'(s) + BIAS_BITS'(SUM_OFFSET);
      p = PROD_BITS'(u) * PROD_BITS'(RECIP);
      return p[RECIP_SHIFT +: SAMPLE_BITS] ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   endfunction

   function automatic corner_sum_type block_sums(column_type l, column_type c, column_type r);
      corner_sum_type t;
      t.ul = corner(l.up, c.up, l.mid, c.mid);
      t.ur = corner(r.up, c.up, r.mid, c.mid);
      t.ll = corner(l.dn, c.dn, l.mid, c.mid);
      t.lr = corner(r.dn, c.dn, r.mid, c.mid);
      return t;
   endfunction

endpackage

### hdl/upsample2x_stencil_line_buffer.sv
// Top level: 2x linear upsampler over a 3x3 stencil with a three-row line memory.
// A request's results are registered in stage 1, stage 2 and the output register.
// Throughput: one request per cycle unless the output register stalls, as it does
// while it holds the two results of a last-column request (one result at width one).
// Reset clears counters, pipeline valids and the registers (all to one);
// the line memory is not cleared and needs no clearing pass.
module upsample2x_stencil_line_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // sample
   input  logic        req_tuser,   // is_drain
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // upper_left, upper_right, lower_left, lower_right,
                                    // center_col, center_row, chan_index
   output logic        rsp_tlast,   // last_of_frame
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   // Configuration, held in bounded form
   logic [us2x_pkg::CHAN_BITS-1:0] nc_m1_ff;
   logic [us2x_pkg::COL_BITS-1:0]  wd_m1_ff;
   logic [us2x_pkg::ROW_BITS-1:0]  ht_ff;

   // Raster position and row slots of the line memory
   logic [us2x_pkg::CHAN_BITS-1:0] ch_ff, ch_in;
   logic [us2x_pkg::COL_BITS-1:0]  col_ff, col_in;
   logic [us2x_pkg::ROW_BITS-1:0]  row_ff, row_in;
   logic [us2x_pkg::SLOT_BITS-1:0] slot_cur_ff, slot_cur_in;
   logic [us2x_pkg::SLOT_BITS-1:0] slot_m1_ff, slot_m1_in;
   logic [us2x_pkg::SLOT_BITS-1:0] slot_m2_ff, slot_m2_in;

   logic csr_write, csr_known, accept, draining, take, ch_last, col_last;

   // Memories
   us2x_pkg::sample_type line_mem [us2x_pkg::LINE_DEPTH];
   us2x_pkg::hist_type   hist_mem [us2x_pkg::MAX_CHAN];
   us2x_pkg::sample_type rd_m1_ff, rd_m2_ff;
   us2x_pkg::hist_type   hist_rd_ff, fwd_data_ff;
   logic                 fwd_ff;

   // Pipeline stages
   logic                 s1_v_ff, s2_v_ff, a_pend_ff, b_pend_ff;
   us2x_pkg::meta_type   s1_meta_ff, s1_meta_in, s2_meta_ff, s3_meta_ff;
   logic                 s1_drain_ff, s1_drain_in;
   us2x_pkg::sample_type s1_sample_ff;
   us2x_pkg::corner_sum_type s2_a_ff, s2_b_ff, sum_a, sum_b;
   us2x_pkg::corner_out_type s3_a_ff, s3_b_ff, out_sel;
   logic en1, en2, en3;

   us2x_pkg::column_type vcur, l_a, l_b;
   us2x_pkg::hist_type   hist_eff, hist_wr;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign csr_known = (csr_index == us2x_pkg::CSR_CHANNEL_COUNT) ||
                      (csr_index == us2x_pkg::CSR_IMAGE_WIDTH) ||
                      (csr_index == us2x_pkg::CSR_IMAGE_HEIGHT);

   // Register writes, saturated into range and stored minus one where useful
   always_ff @(posedge clock) begin
      if (reset) begin
         nc_m1_ff <= '0;
         wd_m1_ff <= '0;
         ht_ff    <= us2x_pkg::ROW_BITS'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            us2x_pkg::CSR_CHANNEL_COUNT: begin
               if (csr_data[4:0] == 5'd0)
                  nc_m1_ff <= '0;
               else if (csr_data[4:0] > 5'(us2x_pkg::MAX_CHAN))
                  nc_m1_ff <= us2x_pkg::CHAN_BITS'(us2x_pkg::MAX_CHAN - 1);
               else
                  nc_m1_ff <= us2x_pkg::CHAN_BITS'(csr_data[4:0] - 5'd1);
            end
            us2x_pkg::CSR_IMAGE_WIDTH: begin
               if (csr_data == 11'd0)
                  wd_m1_ff <= '0;
               else if (csr_data > 11'(us2x_pkg::MAX_WIDTH))
                  wd_m1_ff <= us2x_pkg::COL_BITS'(us2x_pkg::MAX_WIDTH - 1);
               else
                  wd_m1_ff <= us2x_pkg::COL_BITS'(csr_data - 11'd1);
            end
            us2x_pkg::CSR_IMAGE_HEIGHT: begin
               if (csr_data == 11'd0)
                  ht_ff <= us2x_pkg::ROW_BITS'(1);
               else if (csr_data > 11'(us2x_pkg::MAX_HEIGHT))
                  ht_ff <= us2x_pkg::ROW_BITS'(us2x_pkg::MAX_HEIGHT);
               else
                  ht_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Request classification; early drain requests are dropped outright
   assign accept   = req_tvalid && req_tready;
   assign draining = (row_ff == ht_ff);
   assign take     = accept && (draining || !req_tuser);
   assign ch_last  = (ch_ff == nc_m1_ff);
   assign col_last = (col_ff == wd_m1_ff);

   // Position advance, row slots rotate modulo three
   always_comb begin
      ch_in       = ch_ff + 1'b1;
      col_in      = col_ff;
      row_in      = row_ff;
      slot_cur_in = slot_cur_ff;
      slot_m1_in  = slot_m1_ff;
      slot_m2_in  = slot_m2_ff;
      if (ch_last) begin
         ch_in  = '0;
         col_in = col_ff + 1'b1;
         if (col_last) begin
            col_in = '0;
            if (draining) begin
               row_in      = '0;
               slot_cur_in = 2'd0;
               slot_m1_in  = 2'd2;
               slot_m2_in  = 2'd1;
            end else begin
               row_in      = row_ff + 1'b1;
               slot_cur_in = (slot_cur_ff == 2'd2) ? 2'd0 : slot_cur_ff + 2'd1;
               slot_m1_in  = slot_cur_ff;
               slot_m2_in  = slot_m1_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (csr_write && csr_known)) begin
         ch_ff       <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         slot_cur_ff <= 2'd0;
         slot_m1_ff  <= 2'd2;
         slot_m2_ff  <= 2'd1;
      end else if (take) begin
         ch_ff       <= ch_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         slot_cur_ff <= slot_cur_in;
         slot_m1_ff  <= slot_m1_in;
         slot_m2_ff  <= slot_m2_in;
      end
   end

   // Line memory: store current row, fetch the two rows above at the same column
   always_ff @(posedge clock) begin
      if (take && !draining)
         line_mem[{slot_cur_ff, col_ff, ch_ff}] <= req_tdata;
      if (take) begin
         rd_m1_ff <= line_mem[{slot_m1_ff, col_ff, ch_ff}];
         rd_m2_ff <= line_mem[{slot_m2_ff, col_ff, ch_ff}];
      end
   end

   // Column history per channel; forward when the stage ahead writes the same channel
   always_ff @(posedge clock) begin
      if (s1_v_ff && en2)
         hist_mem[s1_meta_ff.ch] <= hist_wr;
      if (take) begin
         hist_rd_ff  <= hist_mem[ch_ff];
         fwd_data_ff <= hist_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         fwd_ff <= 1'b0;
      else if (take)
         fwd_ff <= s1_v_ff && (s1_meta_ff.ch == ch_ff);
   end

   // Handshake: each stage moves when the one after it is free or moving
   assign en3 = !(a_pend_ff || b_pend_ff) || (rsp_tready && (a_pend_ff ^ b_pend_ff));
   assign en2 = !s2_v_ff || en3;
   assign en1 = !s1_v_ff || en2;
   assign req_tready = en1;

   // Stage 1 entry: only rows that produce results go on
   always_comb begin
      s1_meta_in.col    = col_ff;
      s1_meta_in.cy     = us2x_pkg::COL_BITS'(row_ff - 1'b1);
      s1_meta_in.ch     = ch_ff;
      s1_meta_in.emit_a = (col_ff != '0);
      s1_meta_in.emit_b = col_last;
      s1_meta_in.last_b = draining && col_last && ch_last;
      s1_drain_in       = draining;
   end

   always_ff @(posedge clock) begin
      if (reset)
         s1_v_ff <= 1'b0;
      else if (en1)
         s1_v_ff <= take && (row_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_meta_ff   <= s1_meta_in;
         s1_drain_ff  <= s1_drain_in;
         s1_sample_ff <= req_tdata;
      end
   end

   // Stage 1: build columns with vertical clamping, then the corner sums
   always_comb begin
      vcur.mid = rd_m1_ff;
      vcur.up  = (s1_meta_ff.cy == '0) ? rd_m1_ff : rd_m2_ff;
      vcur.dn  = s1_drain_ff ? rd_m1_ff : s1_sample_ff;
      hist_eff = fwd_ff ? fwd_data_ff : hist_rd_ff;
      hist_wr.prev  = vcur;
      hist_wr.prev2 = hist_eff.prev;
      l_a = (s1_meta_ff.col == us2x_pkg::COL_BITS'(1)) ? hist_eff.prev : hist_eff.prev2;
      l_b = (s1_meta_ff.col == '0) ? vcur : hist_eff.prev;
      sum_a = us2x_pkg::block_sums(l_a, hist_eff.prev, vcur);
      sum_b = us2x_pkg::block_sums(l_b, vcur, vcur);
   end

   always_ff @(posedge clock) begin
      if (reset)
         s2_v_ff <= 1'b0;
      else if (en2)
         s2_v_ff <= s1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en2 && s1_v_ff) begin
         s2_meta_ff <= s1_meta_ff;
         s2_a_ff    <= sum_a;
         s2_b_ff    <= sum_b;
      end
   end

   // Stage 2: divide by nine into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_pend_ff <= 1'b0;
         b_pend_ff <= 1'b0;
      end else if (en3) begin
         a_pend_ff <= s2_v_ff && s2_meta_ff.emit_a;
         b_pend_ff <= s2_v_ff && s2_meta_ff.emit_b;
      end else if (rsp_tready) begin
         a_pend_ff <= 1'b0;
         b_pend_ff <= b_pend_ff && a_pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && s2_v_ff) begin
         s3_meta_ff <= s2_meta_ff;
         s3_a_ff.ul <= us2x_pkg::ninth(s2_a_ff.ul);
         s3_a_ff.ur <= us2x_pkg::ninth(s2_a_ff.ur);
         s3_a_ff.ll <= us2x_pkg::ninth(s2_a_ff.ll);
         s3_a_ff.lr <= us2x_pkg::ninth(s2_a_ff.lr);
         s3_b_ff.ul <= us2x_pkg::ninth(s2_b_ff.ul);
         s3_b_ff.ur <= us2x_pkg::ninth(s2_b_ff.ur);
         s3_b_ff.ll <= us2x_pkg::ninth(s2_b_ff.ll);
         s3_b_ff.lr <= us2x_pkg::ninth(s2_b_ff.lr);
      end
   end

   // Output: the left-hand center first, then the last-column center
   assign out_sel    = a_pend_ff ? s3_a_ff : s3_b_ff;
   assign rsp_tvalid = a_pend_ff || b_pend_ff;
   assign rsp_tlast  = !a_pend_ff && s3_meta_ff.last_b;
   assign rsp_tdata  = {s3_meta_ff.ch,
                        s3_meta_ff.cy,
                        a_pend_ff ? us2x_pkg::COL_BITS'(s3_meta_ff.col - 1'b1)
                                  : s3_meta_ff.col,
                        out_sel.lr, out_sel.ll, out_sel.ur, out_sel.ul};

endmodule

### bench/tb_upsample2x_stencil_line_buffer.sv
// Self-checking bench for the 2x stencil upsampler: stream requests in, predicted 2x2 blocks out.
`timescale 1ns / 100ps

module tb_upsample2x_stencil_line_buffer;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT  = 12;
   localparam int HOLD_CYCLES = 300;
   localparam int PROBE_ITEMS = 40;

   typedef struct {
      logic signed [15:0] ul;
      logic signed [15:0] ur;
      logic signed [15:0] ll;
      logic signed [15:0] lr;
      logic [9:0]         col;
      logic [9:0]         row;
      logic [3:0]         ch;
      logic               last;
   } up_block_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // sample
   logic        req_tuser;   // is_drain
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;   // upper_left, upper_right, lower_left, lower_right,
                             // center_col, center_row, chan_index
   logic        rsp_tlast;   // last_of_frame
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [10:0] csr_data;

   upsample2x_stencil_line_buffer u_top (.*);

   // predictor state
   logic signed [15:0] line_mem [0:3*us2x_pkg::MAX_WIDTH*us2x_pkg::MAX_CHAN-1];
   int unsigned chan_pos, col_pos, row_pos;
   int unsigned reg_chan, reg_width, reg_height;
   up_block_type expected_blocks [$];

   int  errors;
   int  cycles;
   bit  idle_on;
   bit  hold_request;

   // clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int unsigned bounded(int unsigned v, int unsigned top);
      if (v < 1) return 1;
      return (v > top) ? top : v;
   endfunction

   function automatic int signed fetch(int unsigned r, int unsigned c, int unsigned ch);
      return 32'(line_mem[((r % 3) * us2x_pkg::MAX_WIDTH + c) * us2x_pkg::MAX_CHAN + ch]);
   endfunction

   // floor((s + 4) / 9)
   function automatic logic signed [15:0] div9_round(int signed s);
      int signed t;
      int signed q;
      t = s + 4;
      q = (t >= 0) ? t / 9 : -((-t + 8) / 9);
      return q[15:0];
   endfunction

   // expected 2x2 block around one center sample
   function automatic up_block_type upsample_block(int unsigned cx, int unsigned cy,
         int unsigned ch, int unsigned wd, int unsigned ht, bit last);
      up_block_type b;
      int unsigned lc, rc, ur, dr;
      int signed p_ul, p_u, p_ur, p_l, p_c, p_r, p_dl, p_d, p_dr;
      lc = cx ? cx - 1 : 0;
      rc = (cx + 1 < wd) ? cx + 1 : wd - 1;
      ur = cy ? cy - 1 : 0;
      dr = (cy + 1 < ht) ? cy + 1 : ht - 1;
      p_ul = fetch(ur, lc, ch); p_u = fetch(ur, cx, ch); p_ur = fetch(ur, rc, ch);
      p_l  = fetch(cy, lc, ch); p_c = fetch(cy, cx, ch); p_r  = fetch(cy, rc, ch);
      p_dl = fetch(dr, lc, ch); p_d = fetch(dr, cx, ch); p_dr = fetch(dr, rc, ch);
      b.ul = div9_round(p_ul + 2 * p_u + 2 * p_l + 4 * p_c);
      b.ur = div9_round(p_ur + 2 * p_u + 2 * p_r + 4 * p_c);
      b.ll = div9_round(p_dl + 2 * p_d + 2 * p_l + 4 * p_c);
      b.lr = div9_round(p_dr + 2 * p_d + 2 * p_r + 4 * p_c);
      b.col = cx[9:0];
      b.row = cy[9:0];
      b.ch = ch[3:0];
      b.last = last;
      return b;
   endfunction

   // advance the predictor by one accepted request
   function automatic void predict_request(logic [15:0] smp, logic drain);
      int unsigned nc, wd, ht, cy;
      bit draining, final_item;
      nc = bounded(reg_chan, us2x_pkg::MAX_CHAN);
      wd = bounded(reg_width, us2x_pkg::MAX_WIDTH);
      ht = bounded(reg_height, us2x_pkg::MAX_HEIGHT);
      if (chan_pos >= nc || col_pos >= wd || row_pos > ht) begin
         chan_pos = 0; col_pos = 0; row_pos = 0;
      end
      draining = (row_pos == ht);
      // drain request before the drain row is ignored
      if (!draining && drain) return;
      if (!draining)
         line_mem[((row_pos % 3) * us2x_pkg::MAX_WIDTH + col_pos) * us2x_pkg::MAX_CHAN
                  + chan_pos] = smp;
      if (row_pos >= 1) begin
         cy = row_pos - 1;
         final_item = draining && col_pos == wd - 1 && chan_pos == nc - 1;
         if (col_pos >= 1)
            expected_blocks.push_back(upsample_block(col_pos - 1, cy, chan_pos, wd, ht,
                                                     final_item && col_pos != wd - 1));
         if (col_pos == wd - 1)
            expected_blocks.push_back(upsample_block(col_pos, cy, chan_pos, wd, ht,
                                                     final_item));
      end
      chan_pos++;
      if (chan_pos >= nc) begin
         chan_pos = 0;
         col_pos++;
         if (col_pos >= wd) begin
            col_pos = 0;
            row_pos++;
            if (row_pos > ht) row_pos = 0;
         end
      end
   endfunction

   // receiver: random stall bursts, plus a long hold on request
   int stall_left;
   int hold_left;
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      up_block_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected result %h last %b", $realtime, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            e = expected_blocks.pop_front();
            if (rsp_tdata[15:0] !== e.ul) begin
               $display("%0t: upper_left exp %h got %h", $realtime, e.ul, rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[31:16] !== e.ur) begin
               $display("%0t: upper_right exp %h got %h", $realtime, e.ur, rsp_tdata[31:16]);
               errors++;
            end
            if (rsp_tdata[47:32] !== e.ll) begin
               $display("%0t: lower_left exp %h got %h", $realtime, e.ll, rsp_tdata[47:32]);
               errors++;
            end
            if (rsp_tdata[63:48] !== e.lr) begin
               $display("%0t: lower_right exp %h got %h", $realtime, e.lr, rsp_tdata[63:48]);
               errors++;
            end
            if (rsp_tdata[73:64] !== e.col) begin
               $display("%0t: center_col exp %0d got %0d", $realtime, e.col, rsp_tdata[73:64]);
               errors++;
            end
            if (rsp_tdata[83:74] !== e.row) begin
               $display("%0t: center_row exp %0d got %0d", $realtime, e.row, rsp_tdata[83:74]);
               errors++;
            end
            if (rsp_tdata[87:84] !== e.ch) begin
               $display("%0t: chan_index exp %0d got %0d", $realtime, e.ch, rsp_tdata[87:84]);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $display("%0t: last_of_frame exp %b got %b", $realtime, e.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // send one request; valid stays high into the next call unless a gap is drawn
   task automatic send_request(logic [15:0] smp, logic drain);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tuser  <= drain;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(smp, drain);
   endtask

   // stop sending and wait until every expected block has come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // valid stays high across back-to-back writes; the caller drops it
   task automatic write_reg(logic [1:0] idx, logic [10:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == us2x_pkg::CSR_CHANNEL_COUNT) reg_chan = 32'(value[4:0]);
      else if (idx == us2x_pkg::CSR_IMAGE_WIDTH) reg_width = 32'(value);
      else if (idx == us2x_pkg::CSR_IMAGE_HEIGHT) reg_height = 32'(value);
      chan_pos = 0; col_pos = 0; row_pos = 0;
   endtask

   task automatic set_geometry(logic [10:0] nc, logic [10:0] wd, logic [10:0] ht);
      wait_idle();
      write_reg(us2x_pkg::CSR_CHANNEL_COUNT, nc);
      write_reg(us2x_pkg::CSR_IMAGE_WIDTH, wd);
      write_reg(us2x_pkg::CSR_IMAGE_HEIGHT, ht);
      csr_valid <= 1'b0;
   endtask

   // one whole frame with random samples, optional stray drains, optionally cut short
   task automatic send_frame(int noise_pct, bit cut);
      int unsigned nc, wd, ht, total, stop_at;
      nc = bounded(reg_chan, us2x_pkg::MAX_CHAN);
      wd = bounded(reg_width, us2x_pkg::MAX_WIDTH);
      ht = bounded(reg_height, us2x_pkg::MAX_HEIGHT);
      total = nc * wd * (ht + 1);
      stop_at = cut ? $urandom_range(1, total) : total;
      for (int unsigned i = 0; i < stop_at; i++) begin
         if (i < nc * wd * ht) begin
            if ($urandom_range(0, 99) < noise_pct)
               send_request(16'($urandom), 1'b1);
            send_request(16'($urandom), 1'b0);
         end else begin
            // drain row: sample ignored, tuser mostly set
            send_request(16'($urandom), $urandom_range(0, 3) != 0);
         end
      end
   endtask

   // extremes of the sample field and the smallest frames
   task automatic test_directed();
      set_geometry(11'd0, 11'd0, 11'd0);
      send_request(16'h8000, 1'b0);
      send_request(16'h7FFF, 1'b1);
      set_geometry(11'd2, 11'd3, 11'd2);
      for (int i = 0; i < 12; i++) begin
         if (i == 5) send_request(16'h1234, 1'b1);
         send_request((i % 3 == 0) ? 16'h7FFF : 16'h8000, 1'b0);
      end
      for (int i = 0; i < 6; i++) send_request(16'h0000, 1'b1);
   endtask

   // register values above the limits saturate; large frames only partly sent
   task automatic test_saturation();
      set_geometry(11'd31, 11'd2, 11'd1);
      send_frame(0, 1'b0);
      set_geometry(11'd1, 11'd2047, 11'd1);
      repeat (PROBE_ITEMS) send_request(16'($urandom), 1'b0);
      set_geometry(11'd1, 11'd1, 11'd2047);
      repeat (PROBE_ITEMS) send_request(16'($urandom), 1'b0);
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      set_geometry(11'd2, 11'd8, 11'd4);
      hold_request = 1'b1;
      send_frame(0, 1'b0);
   endtask

   // random geometries, back-to-back frames, some noise and cut frames
   task automatic test_random(int unsigned items);
      int unsigned start;
      start = 0;
      while (start < items) begin
         if ($urandom_range(0, 9) == 0)
            set_geometry(11'($urandom_range(1, 16)), 11'($urandom_range(1, 3)),
                         11'($urandom_range(1, 3)));
         else
            set_geometry(11'($urandom_range(1, 4)), 11'($urandom_range(1, 8)),
                         11'($urandom_range(1, 5)));
         repeat ($urandom_range(1, 3)) begin
            send_frame($urandom_range(0, 1) ? 0 : 10, $urandom_range(0, 7) == 0);
            start += bounded(reg_chan, us2x_pkg::MAX_CHAN)
                     * bounded(reg_width, us2x_pkg::MAX_WIDTH)
                     * (bounded(reg_height, us2x_pkg::MAX_HEIGHT) + 1);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = us2x_pkg::CSR_CHANNEL_COUNT;
      csr_data = '0;
      errors = 0;
      cycles = 0;
      idle_on = 1'b1;
      hold_request = 1'b0;
      stall_left = 0;
      hold_left = 0;
      reg_chan = 1; reg_width = 1; reg_height = 1;
      chan_pos = 0; col_pos = 0; row_pos = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_saturation();
      test_backpressure();
      test_random(600);
      idle_on = 1'b0;
      test_random(120);

      wait_idle();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
hdl/us2x_pkg.sv
hdl/upsample2x_stencil_line_buffer.sv
bench/tb_upsample2x_stencil_line_buffer.sv
